/* rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, constants and the quarter-sine table of the tape saturator.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int SINE_DEPTH  = 256;
  localparam int IDX_BITS    = $clog2(SINE_DEPTH + 1);
  localparam int POS_BITS    = 16 + IDX_BITS;
  localparam int CFG_BITS    = 24;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
  localparam logic [63:0] HALF_PI_FR  =
    (HALF_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam int REM_BITS = FRAC_BITS + 3;
  localparam logic [REM_BITS-1:0] HP = REM_BITS'(HALF_PI_FR);
  // floor(2^48 / HP): estimate of arg * 2^24 / HP, low by at most one
  localparam logic [63:0] RECIP_HP = (64'd1 << 48) / HALF_PI_FR;

  localparam logic [2:0] REG_INTENSITY = 3'd0;
  localparam logic [2:0] REG_COEFF     = 3'd1;
  localparam logic [2:0] REG_DENSITY   = 3'd2;
  localparam logic [2:0] REG_INV_DENS  = 3'd3;
  localparam logic [2:0] REG_BIAS      = 3'd4;
  localparam logic [2:0] REG_SPAN      = 3'd5;
  localparam logic [2:0] REG_BASS_TRIM = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_beat_t;

  typedef struct packed {
    logic [16:0] coeff;
    logic [18:0] drive;
    logic [16:0] glitch;
    logic [16:0] treble;
    logic [23:0] density;
    logic [17:0] inv_density;
    logic [17:0] bias;
    logic [19:0] span;
    logic [16:0] bass_trim;
  } lane_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

  typedef logic [SINE_DEPTH:0][30:0] sine_tab_t;

  function automatic sine_tab_t build_sine();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      tab[i] = 31'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] r;
    r = s;
    r = r ^ (r << 13);
    r = r ^ (r >> 17);
    r = r ^ (r << 5);
    return r;
  endfunction

endpackage

/* rtl/sts_lane.sv */
// ----------------------------------------------------------------------------
// sts_lane
// One channel: drive, band split, overdrive, flutter, sine clip and trim,
// sequenced one step per cycle, with a reciprocal multiply and a one-step
// correction for the sine table position; the result then waits in DONE until taken.
// ----------------------------------------------------------------------------
module sts_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [sts_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                  phase_i,
  input  logic [31:0]                           rnd_i,
  input  sts_pkg::lane_cfg_t                    cfg_i,
  input  logic                                  take_i,
  output sts_pkg::lane_sts_t                    sts_o,
  output logic signed [sts_pkg::SAMPLE_BITS-1:0] result_o
);

  typedef enum logic [4:0] {
    IDLE, DRIVE, HPF, GLITCH, SQUARE, BASS, LPF, MIX0, MIX1, ARG, DIV,
    QREM, QFIX, TAB, SINE, SCALE, TREB, SUM, DONE
  } state_e;

  localparam int F = sts_pkg::FRAC_BITS;
  localparam int RB = sts_pkg::REM_BITS;
  localparam int IDX_BITS_L = sts_pkg::IDX_BITS;

  state_e state_q;
  logic signed [sts_pkg::SAMPLE_BITS-1:0] x_in_q;
  logic [31:0]        rnd_q;
  logic               phase_q;
  logic signed [31:0] hpe_q, hpo_q, lpe_q, lpo_q;
  logic signed [31:0] hist_q [4];
  logic signed [31:0] x_q, h_q, t_q, t2_q, bass_q, lp_q, y_q, newer_q, older_q;
  logic [21:0]        pos_q;
  logic signed [63:0] p1_q;
  logic [RB-1:0]      rem_q;
  logic [RB-1:0]      r_q;
  logic [sts_pkg::POS_BITS-1:0] q0_q;
  logic [sts_pkg::POS_BITS-1:0] quo_q;
  logic [30:0]        s0_q;
  logic signed [31:0] sd_q;
  logic [15:0]        fr_q;
  logic               edge_q;
  logic [30:0]        s_q;
  logic signed [31:0] yc_q, tre_q;
  logic signed [sts_pkg::SAMPLE_BITS-1:0] res_q;

  logic [2:0]  k;
  logic [15:0] f;
  logic signed [63:0] hp_old, lp_old, hpn, lpn, m, ymag, argw, v, mag;
  logic [IDX_BITS_L-1:0] idx;

  always_comb begin
    k       = (pos_q[21:16] > 6'd4) ? 3'd4 : pos_q[18:16];
    f       = pos_q[15:0];
    hp_old  = phase_q ? 64'(hpo_q) : 64'(hpe_q);
    lp_old  = phase_q ? 64'(lpo_q) : 64'(lpe_q);
    hpn     = sts_pkg::sat32(hp_old + (((64'(x_q) - hp_old)
                * $signed(64'(cfg_i.coeff))) >>> 16));
    m       = sts_pkg::sat32((64'(h_q) * 64'(t2_q)) >>> F);
    lpn     = sts_pkg::sat32(lp_old + (((64'(bass_q) - lp_old)
                * $signed(64'(cfg_i.coeff))) >>> 16));
    ymag    = (y_q < 0) ? -64'(y_q) : 64'(y_q);
    argw    = (ymag * $signed(64'(cfg_i.density))) >>> 16;
    idx     = quo_q[sts_pkg::POS_BITS-1:16];
    mag     = ((($signed(64'(s_q)) * $signed(64'(cfg_i.inv_density))) >>> 24) <<< 1)
              >>> (31 - F);
    v       = 64'(tre_q) + sts_pkg::sat32((64'(lp_q)
                * $signed(64'(cfg_i.bass_trim))) >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      hpe_q <= '0;
      hpo_q <= '0;
      lpe_q <= '0;
      lpo_q <= '0;
      for (int i = 0; i < 4; i++) hist_q[i] <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (start_i) begin
            x_in_q  <= sample_i;
            rnd_q   <= rnd_i;
            phase_q <= phase_i;
            state_q <= DRIVE;
          end
        end
        DRIVE: begin
          x_q <= 32'(sts_pkg::sat32((64'(x_in_q) * $signed(64'(cfg_i.drive))) >>> 16));
          pos_q <= 22'(cfg_i.bias) + 22'((64'(rnd_q) * 64'(cfg_i.span)) >> 32);
          state_q <= HPF;
        end
        HPF: begin
          if (phase_q) hpo_q <= 32'(hpn);
          else hpe_q <= 32'(hpn);
          h_q <= 32'(sts_pkg::sat32(64'(x_q) - hpn));
          state_q <= GLITCH;
        end
        GLITCH: begin
          t_q <= 32'(sts_pkg::sat32((((h_q < 0) ? -64'(h_q) : 64'(h_q))
                   * $signed(64'(cfg_i.glitch))) >>> 16));
          state_q <= SQUARE;
        end
        SQUARE: begin
          t2_q <= 32'(sts_pkg::sat32((64'(t_q) * 64'(t_q)) >>> F));
          state_q <= BASS;
        end
        BASS: begin
          bass_q <= 32'(sts_pkg::sat32(64'(x_q) - m));
          state_q <= LPF;
        end
        LPF: begin
          if (phase_q) lpo_q <= 32'(lpn);
          else lpe_q <= 32'(lpn);
          lp_q <= 32'(lpn);
          case (k)
            3'd0: begin newer_q <= h_q; older_q <= hist_q[0]; end
            3'd1: begin newer_q <= hist_q[0]; older_q <= hist_q[1]; end
            3'd2: begin newer_q <= hist_q[1]; older_q <= hist_q[2]; end
            3'd3: begin newer_q <= hist_q[2]; older_q <= hist_q[3]; end
            default: begin newer_q <= h_q; older_q <= h_q; end
          endcase
          state_q <= MIX0;
        end
        MIX0: begin
          p1_q <= 64'(newer_q) * $signed(64'(f));
          state_q <= MIX1;
        end
        MIX1: begin
          if (k == 3'd4) y_q <= h_q;
          else y_q <= 32'((p1_q + 64'(older_q) * $signed(64'(17'h10000 - 17'(f)))) >>> 16);
          hist_q[3] <= hist_q[2];
          hist_q[2] <= hist_q[1];
          hist_q[1] <= hist_q[0];
          hist_q[0] <= h_q;
          state_q <= ARG;
        end
        ARG: begin
          rem_q <= (argw > $signed(64'(sts_pkg::HP))) ? sts_pkg::HP : RB'(argw);
          state_q <= DIV;
        end
        DIV: begin
          q0_q <= sts_pkg::POS_BITS'((64'(rem_q) * sts_pkg::RECIP_HP) >> 24);
          state_q <= QREM;
        end
        QREM: begin
          r_q <= RB'((64'(rem_q) << 24) - 64'(q0_q) * 64'(sts_pkg::HP));
          state_q <= QFIX;
        end
        QFIX: begin
          quo_q <= (r_q >= sts_pkg::HP) ? q0_q + sts_pkg::POS_BITS'(1) : q0_q;
          state_q <= TAB;
        end
        TAB: begin
          fr_q <= quo_q[15:0];
          if (idx >= IDX_BITS_L'(sts_pkg::SINE_DEPTH)) begin
            edge_q <= 1'b1;
            s0_q <= sts_pkg::SINE_TAB[sts_pkg::SINE_DEPTH];
            sd_q <= '0;
          end else begin
            edge_q <= 1'b0;
            s0_q <= sts_pkg::SINE_TAB[idx];
            sd_q <= $signed({1'b0, sts_pkg::SINE_TAB[idx + IDX_BITS_L'(1)]})
                  - $signed({1'b0, sts_pkg::SINE_TAB[idx]});
          end
          state_q <= SINE;
        end
        SINE: begin
          if (edge_q) s_q <= s0_q;
          else s_q <= 31'($signed(64'(s0_q))
                      + ((64'(sd_q) * $signed(64'(fr_q))) >>> 16));
          state_q <= SCALE;
        end
        SCALE: begin
          yc_q <= (y_q > 0) ? 32'(mag) : 32'(-mag);
          state_q <= TREB;
        end
        TREB: begin
          tre_q <= 32'(sts_pkg::sat32((64'(yc_q)
                     * $signed(64'(cfg_i.treble))) >>> 16));
          state_q <= SUM;
        end
        SUM: begin
          if (v > $signed(64'((64'd1 << F) - 64'd1))) res_q <= {1'b0, {F{1'b1}}};
          else if (v < -$signed(64'd1 << F)) res_q <= {1'b1, {F{1'b0}}};
          else res_q <= sts_pkg::SAMPLE_BITS'(v);
          state_q <= DONE;
        end
        DONE: begin
          if (take_i) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign sts_o.idle = (state_q == IDLE);
  assign sts_o.done = (state_q == DONE);
  assign result_o   = res_q;

endmodule

/* rtl/stereo_tape_saturation_core.sv */
// ----------------------------------------------------------------------------
// stereo_tape_saturation_core
// Stereo tape saturator: two channel lanes side by side, merged into one beat.
// ----------------------------------------------------------------------------
// Each accepted input beat runs through the 17-step lane sequencer and the
// handoff to the output register before out_valid_o; no new frame is taken
// until both lanes are idle again, and a stalled output beat holds the lanes.
// Reset: config registers take their default values, filter and flutter state
// clear, the noise generator seeds to 17 and the frame phase to even.
module stereo_tape_saturation_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sts_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sts_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [sts_pkg::CFG_BITS-1:0] cfg_data_i
);

  logic [16:0] intensity_q, coeff_q, bass_trim_q;
  logic [23:0] density_q;
  logic [17:0] inv_density_q, bias_q;
  logic [19:0] span_q;
  logic [18:0] drive_q;
  logic [16:0] glitch_q, treble_q;
  logic [31:0] noise_q;
  logic        phase_q;
  logic        out_valid_q;
  sts_pkg::out_beat_t out_q;

  sts_pkg::lane_cfg_t lcfg;
  sts_pkg::lane_sts_t sts_l, sts_r;
  logic signed [sts_pkg::SAMPLE_BITS-1:0] res_l, res_r;
  logic        accept, take;
  logic [31:0] rnd_l, rnd_r;
  logic [33:0] isq;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !(sts_l.idle && sts_r.idle);
  assign take = sts_l.done && sts_r.done && (!out_valid_q || !out_stall_i);
  assign rnd_l = sts_pkg::xorshift(noise_q);
  assign rnd_r = sts_pkg::xorshift(rnd_l);
  assign isq = 34'(intensity_q) * 34'(intensity_q);

  always_comb begin
    lcfg.coeff       = coeff_q;
    lcfg.drive       = drive_q;
    lcfg.glitch      = glitch_q;
    lcfg.treble      = treble_q;
    lcfg.density     = density_q;
    lcfg.inv_density = inv_density_q;
    lcfg.bias        = bias_q;
    lcfg.span        = span_q;
    lcfg.bass_trim   = bass_trim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q   <= 17'd75366;
      coeff_q       <= 17'd53106;
      density_q     <= 24'd6094848;
      inv_density_q <= 18'd180400;
      bias_q        <= 18'd24904;
      span_q        <= 20'd54613;
      bass_trim_q   <= 17'd49553;
      drive_q       <= 19'h10000;
      glitch_q      <= '0;
      treble_q      <= 17'h10000;
      noise_q       <= 32'd17;
      phase_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sts_pkg::REG_INTENSITY: intensity_q   <= cfg_data_i[16:0];
          sts_pkg::REG_COEFF:     coeff_q       <= cfg_data_i[16:0];
          sts_pkg::REG_DENSITY:   density_q     <= cfg_data_i[23:0];
          sts_pkg::REG_INV_DENS:  inv_density_q <= cfg_data_i[17:0];
          sts_pkg::REG_BIAS:      bias_q        <= cfg_data_i[17:0];
          sts_pkg::REG_SPAN:      span_q        <= cfg_data_i[19:0];
          sts_pkg::REG_BASS_TRIM: bass_trim_q   <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (intensity_q > 17'h10000) begin
        glitch_q <= intensity_q - 17'h10000;
        drive_q  <= {1'b0, isq[33:16]};
        treble_q <= 17'((18'(intensity_q) + 18'h10000) >> 1);
      end else begin
        glitch_q <= '0;
        drive_q  <= 19'h10000;
        treble_q <= 17'h10000;
      end
      if (accept) begin
        noise_q <= rnd_r;
        phase_q <= !phase_q;
      end
      if (take) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.left_out  <= res_l;
      out_q.right_out <= res_r;
    end
  end

  sts_lane u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (in_data_i.left_sample),
    .phase_i  (phase_q),
    .rnd_i    (rnd_l),
    .cfg_i    (lcfg),
    .take_i   (take),
    .sts_o    (sts_l),
    .result_o (res_l)
  );

  sts_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (in_data_i.right_sample),
    .phase_i  (phase_q),
    .rnd_i    (rnd_r),
    .cfg_i    (lcfg),
    .take_i   (take),
    .sts_o    (sts_r),
    .result_o (res_r)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/stereo_tape_saturation_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_tape_saturation_core_tb
// Drives stereo frames through the tape saturator under random input gaps
// and output stalls, across several register settings. Each accepted frame
// is run through a bit-exact fixed-point predictor, and every output beat is
// compared field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
module stereo_tape_saturation_core_tb;

  localparam int          LIMIT    = 1500000;
  localparam int          HOLD_LEN = 400;
  localparam logic [2:0]  REG_NONE = 3'd7;

  class saturation_scoreboard;
    longint        sine_q30 [sts_pkg::SINE_DEPTH+1];
    longint        half_pi;
    longint        intensity, coeff, density, inv_dens, bias, span, bass_trim;
    longint        hpf [2][2];
    longint        lpf [2][2];
    longint        hist [2][4];
    bit            phase;
    bit [31:0]     noise;
    sts_pkg::out_beat_t frames_due [$];
    int            errors;

    function void reset_state();
      longint unsigned x, x2, term;
      longint sum;
      for (int i = 0; i <= sts_pkg::SINE_DEPTH; i++) begin
        x    = 64'd1686629713 * i / sts_pkg::SINE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
          sum  = (n % 2) ? sum - longint'(term) : sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
        sine_q30[i] = sum;
      end
      half_pi   = (64'sd6746518852 + (64'sd1 << (31 - sts_pkg::FRAC_BITS)))
                  >>> (32 - sts_pkg::FRAC_BITS);
      intensity = 75366;   coeff = 53106;   density = 6094848; inv_dens = 180400;
      bias      = 24904;   span  = 54613;   bass_trim = 49553;
      hpf = '{default: 0}; lpf = '{default: 0}; hist = '{default: 0};
      phase = 0;
      noise = 32'd17;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [sts_pkg::CFG_BITS-1:0] v);
      case (idx)
        sts_pkg::REG_INTENSITY: intensity = v[16:0];
        sts_pkg::REG_COEFF:     coeff     = v[16:0];
        sts_pkg::REG_DENSITY:   density   = v[23:0];
        sts_pkg::REG_INV_DENS:  inv_dens  = v[17:0];
        sts_pkg::REG_BIAS:      bias      = v[17:0];
        sts_pkg::REG_SPAN:      span      = v[19:0];
        sts_pkg::REG_BASS_TRIM: bass_trim = v[16:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mix(longint newer, longint older, longint f);
      return (newer * f + older * (65536 - f)) >>> 16;
    endfunction

    function longint sine_clip(longint y);
      longint unsigned mag, arg, pos, idx, fr;
      longint s;
      mag = (y < 0) ? -y : y;
      arg = (mag * density) >> 16;
      if (arg > half_pi) arg = half_pi;
      pos = ((arg * sts_pkg::SINE_DEPTH) << 16) / half_pi;
      idx = pos >> 16;
      fr  = pos & 64'hFFFF;
      if (idx >= sts_pkg::SINE_DEPTH) s = sine_q30[sts_pkg::SINE_DEPTH];
      else s = sine_q30[idx] + (((sine_q30[idx+1] - sine_q30[idx]) * longint'(fr)) >>> 16);
      mag = (longint'(s) * inv_dens) >> 24;
      mag = (mag << 1) >> (31 - sts_pkg::FRAC_BITS);
      return (y > 0) ? longint'(mag) : -longint'(mag);
    endfunction

    function longint channel_out(int c, longint x_in, longint drive, longint glitch,
                                 longint treble);
      longint x, h, t, t2, bass, y, pos, k, f;
      x = clamp32((x_in * drive) >>> 16);
      hpf[phase][c] = clamp32(hpf[phase][c] + (((x - hpf[phase][c]) * coeff) >>> 16));
      h = clamp32(x - hpf[phase][c]);
      t  = clamp32((((h < 0) ? -h : h) * glitch) >>> 16);
      t2 = clamp32((t * t) >>> sts_pkg::FRAC_BITS);
      bass = clamp32(x - clamp32((h * t2) >>> sts_pkg::FRAC_BITS));
      lpf[phase][c] = clamp32(lpf[phase][c] + (((bass - lpf[phase][c]) * coeff) >>> 16));
      noise = noise ^ (noise << 13);
      noise = noise ^ (noise >> 17);
      noise = noise ^ (noise << 5);
      pos = bias + longint'((64'(noise) * 64'(span)) >> 32);
      k = pos >>> 16;
      f = pos & 64'hFFFF;
      if (k == 0) y = mix(h, hist[c][0], f);
      else if (k < 4) y = mix(hist[c][k-1], hist[c][k], f);
      else y = h;
      hist[c][3] = hist[c][2]; hist[c][2] = hist[c][1];
      hist[c][1] = hist[c][0]; hist[c][0] = h;
      y = sine_clip(y);
      return clamp32((y * treble) >>> 16) + clamp32((lpf[phase][c] * bass_trim) >>> 16);
    endfunction

    function void note_frame(sts_pkg::in_beat_t b);
      longint drive, glitch, treble, v;
      longint smp [2];
      sts_pkg::out_beat_t o;
      drive = 65536; glitch = 0; treble = 65536;
      if (intensity > 65536) begin
        glitch = intensity - 65536;
        drive  = (intensity * intensity) >> 16;
        treble = (intensity + 65536) >> 1;
      end
      smp[0] = b.left_sample;
      smp[1] = b.right_sample;
      for (int c = 0; c < 2; c++) begin
        v = channel_out(c, smp[c], drive, glitch, treble);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        if (c == 0) o.left_out = v[sts_pkg::SAMPLE_BITS-1:0];
        else o.right_out = v[sts_pkg::SAMPLE_BITS-1:0];
      end
      phase ^= 1'b1;
      frames_due.push_back(o);
    endfunction

    function void check_frame(sts_pkg::out_beat_t got);
      sts_pkg::out_beat_t exp_f;
      if (frames_due.size() == 0) begin
        $error("unexpected output beat %h", got);
        errors++;
        return;
      end
      exp_f = frames_due.pop_front();
      if (got.left_out !== exp_f.left_out) begin
        $error("left_out: expected %0d, got %0d", exp_f.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== exp_f.right_out) begin
        $error("right_out: expected %0d, got %0d", exp_f.right_out, got.right_out);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i, rst_ni;
  logic                         in_valid_i, in_stall_o;
  sts_pkg::in_beat_t            in_data_i;
  logic                         out_valid_o, out_stall_i;
  sts_pkg::out_beat_t           out_data_o;
  logic                         cfg_we_i;
  logic [2:0]                   cfg_index_i;
  logic [sts_pkg::CFG_BITS-1:0] cfg_data_i;

  saturation_scoreboard sb;
  bit                   hold_req;
  int                   cycles;

  stereo_tape_saturation_core dut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_frame(in_data_i);
    if (out_valid_o && !out_stall_i) sb.check_frame(out_data_o);
  end

  // receiver stall pattern, with a long hold on request
  int stall_mode, stall_cnt, hold_cnt;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_req && hold_cnt == 0) hold_cnt <= HOLD_LEN;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    if (hold_cnt > 1) out_stall_i <= 1'b1;
    else case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 0);
      2: out_stall_i <= (stall_cnt % 7) < 3;
      default: out_stall_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_frame(sts_pkg::in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= sts_pkg::CFG_BITS'(v);
    sb.set_reg(idx, sts_pkg::CFG_BITS'(v));
    @(posedge clk_i);
  endtask

  function automatic sts_pkg::in_beat_t rand_frame();
    sts_pkg::in_beat_t b;
    case ($urandom_range(0, 5))
      0: b = {24'(signed'($urandom_range(0, 2000)) - 1000), 24'($urandom)};
      1: b = {24'h7FFFFF, 24'h800000};
      2: b = {24'($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000), 24'($urandom)};
      default: b = {24'($urandom), 24'($urandom)};
    endcase
    return b;
  endfunction

  task automatic random_run(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        send_frame(rand_frame());
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 60));
    end
  endtask

  task automatic configure(int setting);
    case (setting)
      0: begin
        write_reg(sts_pkg::REG_INTENSITY, 58982);
        write_reg(sts_pkg::REG_COEFF, 0);
        write_reg(sts_pkg::REG_DENSITY, 4784128);
        write_reg(sts_pkg::REG_INV_DENS, 109655);
        write_reg(sts_pkg::REG_BIAS, 0);
        write_reg(sts_pkg::REG_SPAN, 0);
        write_reg(sts_pkg::REG_BASS_TRIM, 0);
      end
      1: begin
        write_reg(sts_pkg::REG_INTENSITY, 124518);
        write_reg(sts_pkg::REG_COEFF, 131071);
        write_reg(sts_pkg::REG_DENSITY, 10027008);
        write_reg(sts_pkg::REG_INV_DENS, 229824);
        write_reg(sts_pkg::REG_BIAS, 262143);
        write_reg(sts_pkg::REG_SPAN, 1048575);
        write_reg(sts_pkg::REG_BASS_TRIM, 65536);
      end
      2: begin
        write_reg(sts_pkg::REG_INTENSITY, $urandom_range(58982, 124518));
        write_reg(sts_pkg::REG_COEFF, $urandom_range(0, 131071));
        write_reg(sts_pkg::REG_DENSITY, $urandom_range(4784128, 10027008));
        write_reg(sts_pkg::REG_INV_DENS, $urandom_range(109655, 229824));
        write_reg(sts_pkg::REG_BIAS, $urandom_range(0, 200000));
        write_reg(sts_pkg::REG_SPAN, $urandom_range(0, 300000));
        write_reg(sts_pkg::REG_BASS_TRIM, $urandom_range(0, 65536));
        write_reg(REG_NONE, $urandom);
      end
      default: begin
        for (int i = 0; i <= 7; i++) write_reg(i[2:0], $urandom);
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    cfg_we_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    hold_req = 0; cycles = 0; stall_mode = 0; stall_cnt = 0; hold_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at reset settings
    send_frame({24'h000000, 24'h000000});
    send_frame({24'h7FFFFF, 24'h7FFFFF});
    send_frame({24'h800000, 24'h800000});
    send_frame({24'h7FFFFF, 24'h800000});
    send_frame({24'h800000, 24'h7FFFFF});
    send_frame({24'h000001, 24'hFFFFFF});
    gap(3);
    send_frame({24'h400000, 24'hC00000});
    send_frame({24'h555555, 24'hAAAAAA});
    wait_drained();

    // long output hold while input keeps coming
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (int i = 0; i < 16; i++) send_frame(rand_frame());
    wait_drained();

    configure(0);
    for (int i = 0; i < 6; i++) send_frame(rand_frame());
    wait_drained();
    configure(1);
    for (int i = 0; i < 6; i++) send_frame(rand_frame());
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      configure(p % 4);
      random_run(140);
      wait_drained();
      random_run(140);
      wait_drained();
    end

    if (sb.errors == 0 && sb.frames_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
